// ----- rtl/core/lfoem_pkg.sv -----
package lfoem_pkg;

   // default sizes for the top-level parameters
   localparam int DEF_PHASE_BITS = 24;
   localparam int DEF_FRAME_BITS = 24;
   localparam int DEF_SINE_DEPTH = 256;

   // configuration port
   localparam int CFG_W       = 24;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_DELAY_FRAMES    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK_FRAMES   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK_GAIN     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_INCREMENT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_WAVE_SHAPE      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MOD_AMOUNT      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_MULTIPLY_MODE   = 3'd6;

   // shared multiplier B operand width (holds wave*mod and Q0.24 gain)
   localparam int MUL_B_W = 32;

   // Q1.24 unity envelope
   localparam logic [24:0] ENV_ONE = 25'h100_0000;

   localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
   localparam logic signed [15:0] Q15_MIN = -16'sh8000;

   // quarter-wave sine build (Q30 Taylor series)
   localparam longint Q30_ONE     = 64'd1073741824;
   localparam longint HALF_PI_Q30 = 64'd1686629713;
   localparam longint TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

   typedef enum logic [1:0] {
      STAGE_OFF,
      STAGE_DELAY,
      STAGE_ATTACK,
      STAGE_SUSTAIN
   } env_stage_type;

   typedef enum logic [1:0] {
      WAVE_SINE,
      WAVE_TRIANGLE,
      WAVE_SAW,
      WAVE_SQUARE
   } wave_shape_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_ENV_MUL,
      SEQ_ENV_CAP,
      SEQ_WAVE_MUL,
      SEQ_LFO_MUL,
      SEQ_LFO,
      SEQ_GAIN_MUL,
      SEQ_FINISH
   } seq_state_type;

   // per-transaction strobes to the envelope and oscillator
   typedef struct packed {
      logic trigger;
      logic step;
   } item_ctrl_type;

   // one table entry from its Q30 angle; elaboration only
   function automatic logic [15:0] sine_entry(input longint angle);
      longint term;
      longint sum;
      term = angle;
      sum  = angle;
      for (int k = 1; k <= 6; k++) begin
         term = term * angle / Q30_ONE;
         term = term * angle / Q30_ONE;
         term = -term / TAYLOR_DIV[k];
         sum  = sum + term;
      end
      if (sum < 0) begin
         sum = 0;
      end
      return 16'((sum * 64'd32767 + (Q30_ONE / 2)) / Q30_ONE);
   endfunction

   function automatic logic signed [15:0] sat_q15(input logic signed [17:0] v);
      if (v > 18'sd32767) begin
         return Q15_MAX;
      end else if (v < -18'sd32768) begin
         return Q15_MIN;
      end
      return v[15:0];
   endfunction

endpackage

// ----- rtl/core/lfoem_env.sv -----
module lfoem_env
   import lfoem_pkg::*;
#(
   parameter int FRAME_BITS = DEF_FRAME_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  item_ctrl_type         ctrl,
   input  logic [CFG_W-1:0]      delay_frames,
   input  logic [CFG_W-1:0]      attack_frames,
   output env_stage_type         stage,
   output logic [FRAME_BITS-1:0] frame_count
);

   env_stage_type         stage_ff, stage_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [FRAME_BITS-1:0] length_ff, length_in;

   logic [FRAME_BITS-1:0] delay_len;
   logic [FRAME_BITS-1:0] attack_len;
   logic [FRAME_BITS:0]   next_count;

   assign delay_len  = FRAME_BITS'(delay_frames);
   assign attack_len = FRAME_BITS'(attack_frames);
   // one bit wider so the end-of-stage compare never wraps
   assign next_count = {1'b0, frame_ff} + {{FRAME_BITS{1'b0}}, 1'b1};

   always_comb begin
      stage_in  = stage_ff;
      frame_in  = frame_ff;
      length_in = length_ff;
      if (ctrl.trigger) begin
         frame_in = '0;
         if (delay_frames != '0) begin
            stage_in  = STAGE_DELAY;
            length_in = delay_len;
         end else if (attack_frames != '0) begin
            stage_in  = STAGE_ATTACK;
            length_in = attack_len;
         end else begin
            stage_in  = STAGE_SUSTAIN;
            length_in = '0;
         end
      end else if (ctrl.step) begin
         case (stage_ff)
            STAGE_DELAY: begin
               frame_in = next_count[FRAME_BITS-1:0];
               if (next_count > {1'b0, length_ff}) begin
                  frame_in = '0;
                  if (attack_frames != '0) begin
                     stage_in  = STAGE_ATTACK;
                     length_in = attack_len;
                  end else begin
                     stage_in  = STAGE_SUSTAIN;
                     length_in = '0;
                  end
               end
            end
            STAGE_ATTACK: begin
               frame_in = next_count[FRAME_BITS-1:0];
               if (next_count >= {1'b0, length_ff}) begin
                  frame_in  = '0;
                  stage_in  = STAGE_SUSTAIN;
                  length_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff  <= STAGE_OFF;
         frame_ff  <= '0;
         length_ff <= '0;
      end else begin
         stage_ff  <= stage_in;
         frame_ff  <= frame_in;
         length_ff <= length_in;
      end
   end

   assign stage       = stage_ff;
   assign frame_count = frame_ff;

endmodule

// ----- rtl/core/lfoem_wave.sv -----
module lfoem_wave
   import lfoem_pkg::*;
#(
   parameter int PHASE_BITS       = DEF_PHASE_BITS,
   parameter int SINE_TABLE_DEPTH = DEF_SINE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  item_ctrl_type      ctrl,
   input  logic [CFG_W-1:0]   phase_increment,
   input  wave_shape_type     wave_shape,
   output logic signed [15:0] wave
);

   localparam int SUM_W      = ((PHASE_BITS > CFG_W) ? PHASE_BITS : CFG_W) + 1;
   localparam int QUAD_DEPTH = 4 * SINE_TABLE_DEPTH;
   localparam int IDX_W      = $clog2(QUAD_DEPTH);
   localparam int SCALE_W    = $clog2(QUAD_DEPTH + 1);
   localparam int SCALED_W   = PHASE_BITS + SCALE_W;
   localparam int ADDR_W     = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int ROM_W      = $clog2(SINE_TABLE_DEPTH);

   localparam logic [IDX_W-1:0]  ONE_QUAD   = IDX_W'(SINE_TABLE_DEPTH);
   localparam logic [IDX_W-1:0]  TWO_QUAD   = IDX_W'(2 * SINE_TABLE_DEPTH);
   localparam logic [IDX_W-1:0]  THREE_QUAD = IDX_W'(3 * SINE_TABLE_DEPTH);
   localparam logic [ADDR_W-1:0] PEAK_ADDR  = ADDR_W'(SINE_TABLE_DEPTH);

   // quarter-wave table, constant
   logic [15:0] sine_rom [SINE_TABLE_DEPTH];

   for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
      localparam longint ANGLE = (HALF_PI_Q30 * gi) / SINE_TABLE_DEPTH;
      assign sine_rom[gi] = sine_entry(ANGLE);
   end

   // phase accumulator
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [SUM_W-1:0]      phase_sum;

   assign phase_sum = SUM_W'(phase_ff) + SUM_W'(phase_increment);

   always_comb begin
      phase_in = phase_ff;
      if (ctrl.trigger) begin
         phase_in = '0;
      end else if (ctrl.step) begin
         phase_in = phase_sum[PHASE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // stage 1: quadrant, table address, non-sine shapes
   logic [PHASE_BITS+15:0] u_wide;
   logic [15:0]            u;
   logic [SCALED_W-1:0]    scaled;
   logic [IDX_W-1:0]       idx;
   logic [IDX_W-1:0]       k_wide;
   logic [1:0]             quad;
   logic [ADDR_W-1:0]      k_addr;
   logic [ADDR_W-1:0]      addr_comb;
   logic signed [17:0]     tri_val;
   logic signed [15:0]     alt_comb;

   assign u_wide = {phase_ff, 16'h0000};
   assign u      = u_wide[PHASE_BITS+15:PHASE_BITS];
   assign scaled = SCALED_W'(phase_ff) * SCALED_W'(QUAD_DEPTH);
   assign idx    = scaled[PHASE_BITS+IDX_W-1:PHASE_BITS];

   always_comb begin
      if (idx >= THREE_QUAD) begin
         quad   = 2'd3;
         k_wide = idx - THREE_QUAD;
      end else if (idx >= TWO_QUAD) begin
         quad   = 2'd2;
         k_wide = idx - TWO_QUAD;
      end else if (idx >= ONE_QUAD) begin
         quad   = 2'd1;
         k_wide = idx - ONE_QUAD;
      end else begin
         quad   = 2'd0;
         k_wide = idx;
      end
   end

   // falling quadrants read the table backwards; the peak sits past its end
   assign k_addr    = ADDR_W'(k_wide);
   assign addr_comb = quad[0] ? (PEAK_ADDR - k_addr) : k_addr;

   always_comb begin
      if (u <= 16'd16384) begin
         tri_val = $signed({1'b0, u, 1'b0});
      end else if (u <= 16'd49152) begin
         tri_val = 18'sd65536 - $signed({1'b0, u, 1'b0});
      end else begin
         tri_val = $signed({u[15], u, 1'b0});
      end
   end

   always_comb begin
      case (wave_shape)
         WAVE_TRIANGLE: alt_comb = sat_q15(tri_val);
         WAVE_SAW:      alt_comb = $signed(u);
         WAVE_SQUARE:   alt_comb = (u > 16'd32768) ? -16'sd32767 : 16'sd32767;
         default:       alt_comb = '0;
      endcase
   end

   logic [ADDR_W-1:0]  addr_ff;
   logic               neg_ff;
   logic signed [15:0] alt_ff;

   always_ff @(posedge clock) begin
      addr_ff <= addr_comb;
      neg_ff  <= quad[1];
      alt_ff  <= alt_comb;
   end

   // stage 2: table read
   logic [15:0]        rom_ff;
   logic               neg2_ff;
   logic signed [15:0] alt2_ff;

   always_ff @(posedge clock) begin
      if (addr_ff == PEAK_ADDR) begin
         rom_ff <= 16'h7FFF;
      end else begin
         rom_ff <= sine_rom[addr_ff[ROM_W-1:0]];
      end
      neg2_ff <= neg_ff;
      alt2_ff <= alt_ff;
   end

   // stage 3: sign and shape select
   logic signed [15:0] wave_ff, wave_in;

   always_comb begin
      if (wave_shape == WAVE_SINE) begin
         wave_in = neg2_ff ? -$signed(rom_ff) : $signed(rom_ff);
      end else begin
         wave_in = alt2_ff;
      end
   end

   always_ff @(posedge clock) begin
      wave_ff <= wave_in;
   end

   assign wave = wave_ff;

endmodule

// ----- rtl/core/lfoem_mul.sv -----
module lfoem_mul #(
   parameter int A_W = 26,
   parameter int B_W = 32
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic signed [A_W-1:0]       a,
   input  logic signed [B_W-1:0]       b,
   output logic signed [A_W+B_W-1:0]   prod
);

   logic signed [A_W+B_W-1:0] prod_ff, prod_in;

   // holds its product until the next load
   assign prod_in = load ? (A_W + B_W)'(a * b) : prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/core/lfo_envelope_modulator.sv -----
// Trigger transaction: taken directly in IDLE, gives no result; ready again next cycle.
// Sample transaction: ENV_MUL to LFO, GAIN_MUL in multiply mode, FINISH loads the result.
// A new sample is taken only once the last one has left FINISH; its passes go through the
//   single shared multiplier, and req_ready is low while a sample is in work.
// Reset (synchronous): config registers zero, envelope off, phase zero, no result pending.
//   The sine table is constant, so no clearing pass follows reset.
module lfo_envelope_modulator
   import lfoem_pkg::*;
#(
   parameter int PHASE_BITS       = DEF_PHASE_BITS,
   parameter int FRAME_BITS       = DEF_FRAME_BITS,
   parameter int SINE_TABLE_DEPTH = DEF_SINE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // input transactions
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic signed [15:0]     req_sample_in,
   // result transactions
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [15:0]     rsp_sample_out,
   output logic                   rsp_envelope_active,
   // register writes
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   // Shared multiplier: A holds a frame count, wave, Q1.24 envelope or sample; B holds the
   // attack gain, mod, wave*mod or 0.5+lfo. One extra bit keeps unsigned values positive.
   localparam int MUL_A_W = ((FRAME_BITS > 25) ? FRAME_BITS : 25) + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [MUL_P_W-1:0] LFO_ROUND  = MUL_P_W'(1) << 39;
   localparam logic [MUL_P_W-1:0] GAIN_ROUND = MUL_P_W'(1) << 14;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CFG_W-1:0]   delay_frames_ff, delay_frames_in;
   logic [CFG_W-1:0]   attack_frames_ff, attack_frames_in;
   logic [CFG_W-1:0]   attack_gain_ff, attack_gain_in;
   logic [CFG_W-1:0]   phase_increment_ff, phase_increment_in;
   wave_shape_type     wave_shape_ff, wave_shape_in;
   logic signed [15:0] mod_amount_ff, mod_amount_in;
   logic               multiply_mode_ff, multiply_mode_in;

   always_comb begin
      delay_frames_in    = delay_frames_ff;
      attack_frames_in   = attack_frames_ff;
      attack_gain_in     = attack_gain_ff;
      phase_increment_in = phase_increment_ff;
      wave_shape_in      = wave_shape_ff;
      mod_amount_in      = mod_amount_ff;
      multiply_mode_in   = multiply_mode_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_DELAY_FRAMES:    delay_frames_in    = csr_wdata;
            REG_ATTACK_FRAMES:   attack_frames_in   = csr_wdata;
            REG_ATTACK_GAIN:     attack_gain_in     = csr_wdata;
            REG_PHASE_INCREMENT: phase_increment_in = csr_wdata;
            REG_WAVE_SHAPE:      wave_shape_in      = wave_shape_type'(csr_wdata[1:0]);
            REG_MOD_AMOUNT:      mod_amount_in      = $signed(csr_wdata[15:0]);
            REG_MULTIPLY_MODE:   multiply_mode_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_frames_ff    <= '0;
         attack_frames_ff   <= '0;
         attack_gain_ff     <= '0;
         phase_increment_ff <= '0;
         wave_shape_ff      <= WAVE_SINE;
         mod_amount_ff      <= '0;
         multiply_mode_ff   <= 1'b0;
      end else begin
         delay_frames_ff    <= delay_frames_in;
         attack_frames_ff   <= attack_frames_in;
         attack_gain_ff     <= attack_gain_in;
         phase_increment_ff <= phase_increment_in;
         wave_shape_ff      <= wave_shape_in;
         mod_amount_ff      <= mod_amount_in;
         multiply_mode_ff   <= multiply_mode_in;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   //   IDLE      take a transaction; a trigger is handled here directly
   //   ENV_MUL   frame_count * attack_gain
   //   ENV_CAP   pick envelope for the stage, clip the attack ramp at 1.0
   //   WAVE_MUL  wave * mod_amount (wave pipeline has settled by now)
   //   LFO_MUL   envelope * (wave * mod)
   //   LFO       round and drop 40 fraction bits -> Q1.15 lfo
   //   GAIN_MUL  sample * (0.5 + lfo), multiply mode only
   //   FINISH    saturate, load result register, step envelope and phase
   // ------------------------------------------------------------------
   seq_state_type state_ff, state_in;

   logic accept;
   logic finish_fire;

   item_ctrl_type                ctrl;
   env_stage_type                stage;
   logic [FRAME_BITS-1:0]        frame_count;
   logic signed [15:0]           wave;

   logic                         mul_load;
   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic signed [MUL_P_W-1:0]    prod;

   logic signed [15:0]           sample_ff, sample_in;
   logic [24:0]                  env_ff, env_in;
   logic signed [16:0]           lfo_ff, lfo_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]           rsp_sample_ff, rsp_sample_in;
   logic                         rsp_active_ff, rsp_active_in;

   assign accept      = req_valid & req_ready;
   assign finish_fire = (state_ff == SEQ_FINISH) & (~rsp_valid_ff | rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept && !req_mode) begin
               state_in = SEQ_ENV_MUL;
            end
         end
         SEQ_ENV_MUL:  state_in = SEQ_ENV_CAP;
         SEQ_ENV_CAP:  state_in = SEQ_WAVE_MUL;
         SEQ_WAVE_MUL: state_in = SEQ_LFO_MUL;
         SEQ_LFO_MUL:  state_in = SEQ_LFO;
         SEQ_LFO:      state_in = multiply_mode_ff ? SEQ_GAIN_MUL : SEQ_FINISH;
         SEQ_GAIN_MUL: state_in = SEQ_FINISH;
         SEQ_FINISH: begin
            if (finish_fire) begin
               state_in = SEQ_IDLE;
            end
         end
         default:      state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer outputs: handshake, strobes and multiplier operands
   logic signed [16:0] gain;

   assign gain = 17'sd16384 + lfo_ff;

   always_comb begin
      req_ready    = (state_ff == SEQ_IDLE);
      ctrl.trigger = accept & req_mode;
      ctrl.step    = finish_fire;
      mul_load     = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         SEQ_ENV_MUL: begin
            mul_load = 1'b1;
            mul_a    = $signed(MUL_A_W'(frame_count));
            mul_b    = $signed(MUL_B_W'(attack_gain_ff));
         end
         SEQ_WAVE_MUL: begin
            mul_load = 1'b1;
            mul_a    = MUL_A_W'(wave);
            mul_b    = MUL_B_W'(mod_amount_ff);
         end
         SEQ_LFO_MUL: begin
            mul_load = 1'b1;
            mul_a    = MUL_A_W'($signed({1'b0, env_ff}));
            mul_b    = $signed(prod[MUL_B_W-1:0]);
         end
         SEQ_GAIN_MUL: begin
            mul_load = 1'b1;
            mul_a    = MUL_A_W'(sample_ff);
            mul_b    = MUL_B_W'(gain);
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath
   // ------------------------------------------------------------------
   logic [MUL_P_W-1:0]  lfo_sum;
   logic [MUL_P_W-1:0]  gain_sum;
   logic signed [16:0]  gain_q15;
   logic signed [15:0]  result;

   assign lfo_sum  = $unsigned(prod) + LFO_ROUND;
   assign gain_sum = $unsigned(prod) + GAIN_ROUND;
   assign gain_q15 = $signed(gain_sum[31:15]);

   always_comb begin
      if (multiply_mode_ff) begin
         result = sat_q15(18'(gain_q15));
      end else begin
         result = sat_q15(18'(sample_ff) + 18'(lfo_ff));
      end
   end

   always_comb begin
      sample_in = sample_ff;
      env_in    = env_ff;
      lfo_in    = lfo_ff;
      if (accept) begin
         sample_in = req_sample_in;
      end
      if (state_ff == SEQ_ENV_CAP) begin
         case (stage)
            STAGE_ATTACK: begin
               if ($unsigned(prod) > MUL_P_W'(ENV_ONE)) begin
                  env_in = ENV_ONE;
               end else begin
                  env_in = prod[24:0];
               end
            end
            STAGE_SUSTAIN: env_in = ENV_ONE;
            default:       env_in = '0;
         endcase
      end
      if (state_ff == SEQ_LFO) begin
         lfo_in = $signed(lfo_sum[56:40]);
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      env_ff    <= env_in;
      lfo_ff    <= lfo_in;
   end

   // result register: the next transaction may be taken while this one waits
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_active_in = rsp_active_ff;
      if (finish_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = result;
         // stage is still the pre-step one; a step never returns to off
         rsp_active_in = (stage != STAGE_OFF);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sample_ff <= rsp_sample_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sample_out      = rsp_sample_ff;
   assign rsp_envelope_active = rsp_active_ff;

   // ------------------------------------------------------------------
   // Units
   // ------------------------------------------------------------------
   lfoem_env #(
      .FRAME_BITS (FRAME_BITS)
   ) u_env (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .delay_frames  (delay_frames_ff),
      .attack_frames (attack_frames_ff),
      .stage         (stage),
      .frame_count   (frame_count)
   );

   lfoem_wave #(
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_wave (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .phase_increment (phase_increment_ff),
      .wave_shape      (wave_shape_ff),
      .wave            (wave)
   );

   lfoem_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock (clock),
      .load  (mul_load),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

endmodule

// ----- rtl/core/lfoem_checker.sv -----
module lfoem_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_mode,
   input logic [15:0] req_sample_in,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_sample_out,
   input logic        rsp_envelope_active,
   input logic        csr_write_en,
   input logic [2:0]  csr_index,
   input logic [23:0] csr_wdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
         && $stable(rsp_envelope_active))
      else $error("stalled result changed or dropped");

   // a trigger transaction leaves the block ready
   a_trigger_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode |=> req_ready)
      else $error("block busy after trigger");

   // a sample transaction keeps the block busy for its multiplier passes
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_mode |=>
         !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("block ready too early after sample");

   // a new result only shows up out of a busy period
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without work in progress");

endmodule

bind lfo_envelope_modulator lfoem_checker u_lfoem_checker (.*);

// ----- dv/lfo_envelope_modulator_checker.sv -----
`timescale 1ns / 100ps

module lfo_envelope_modulator_checker
   import lfoem_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_mode,
   input  logic signed [15:0]     req_sample_in,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic signed [15:0]     rsp_sample_out,
   input  logic                   rsp_envelope_active,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   localparam int     PH_BITS          = DEF_PHASE_BITS;
   localparam int     FR_BITS          = DEF_FRAME_BITS;
   localparam int     SINE_DEPTH       = DEF_SINE_DEPTH;
   localparam longint FRAME_MASK       = (longint'(1) << FR_BITS) - 1;
   localparam longint PHASE_MASK       = (longint'(1) << PH_BITS) - 1;
   localparam longint UNITY            = longint'(1) << 24;
   localparam longint LFO_ROUND        = longint'(1) << 39;
   localparam longint Q30              = 64'sd1073741824;
   localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
   localparam int     REPORT_LIMIT     = 10;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               active;
   } mod_result_t;

   logic [23:0]        cfg_delay, cfg_attack, cfg_gain, cfg_step;
   wave_shape_type     cfg_wave;
   logic signed [15:0] cfg_depth;
   logic               cfg_mult;

   env_stage_type env_stage;
   longint        frames_done, stage_len, phase_acc;
   longint        sine_quarter [SINE_DEPTH];
   mod_result_t   expected_q [$];
   int            mismatches = 0;

   // quarter-wave table, Q30 Taylor series rounded to Q1.15
   initial begin : build_sine
      longint ang, term, total;
      for (int i = 0; i < SINE_DEPTH; i++) begin
         ang   = (QUARTER_TURN_Q30 * i) / SINE_DEPTH;
         term  = ang;
         total = ang;
         for (int k = 1; k <= 6; k++) begin
            term  = term * ang / Q30;
            term  = term * ang / Q30;
            term  = -term / longint'((2 * k) * (2 * k + 1));
            total = total + term;
         end
         if (total < 0) begin
            total = 0;
         end
         sine_quarter[i] = (total * 32767 + Q30 / 2) / Q30;
      end
   end

   function automatic longint clamp_q15(input longint v);
      if (v > 32767) begin
         return 32767;
      end
      if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   // first stage with a nonzero length, after the current one
   function automatic void enter_next_stage();
      frames_done = 0;
      if (env_stage == STAGE_OFF && cfg_delay != 0) begin
         env_stage = STAGE_DELAY;
         stage_len = cfg_delay & FRAME_MASK;
      end else if ((env_stage == STAGE_OFF || env_stage == STAGE_DELAY) && cfg_attack != 0) begin
         env_stage = STAGE_ATTACK;
         stage_len = cfg_attack & FRAME_MASK;
      end else begin
         env_stage = STAGE_SUSTAIN;
         stage_len = 0;
      end
   endfunction

   function automatic longint wave_sample();
      longint u, idx, quad, k, v;
      u = (phase_acc << 16) >> PH_BITS;
      case (cfg_wave)
         WAVE_SINE: begin
            idx  = (phase_acc * (4 * SINE_DEPTH)) >> PH_BITS;
            quad = idx / SINE_DEPTH;
            k    = idx % SINE_DEPTH;
            if (quad[0]) begin
               k = SINE_DEPTH - k;
            end
            v = (k < SINE_DEPTH) ? sine_quarter[k] : 32767;
            if (quad[1]) begin
               v = -v;
            end
         end
         WAVE_TRIANGLE: begin
            if (u <= 16384) begin
               v = 2 * u;
            end else if (u <= 49152) begin
               v = 65536 - 2 * u;
            end else begin
               v = 2 * u - 131072;
            end
         end
         WAVE_SAW: v = (u < 32768) ? u : u - 65536;
         default:  v = (u > 32768) ? -32767 : 32767;
      endcase
      return clamp_q15(v);
   endfunction

   function automatic mod_result_t modulate_sample(input logic signed [15:0] s);
      longint      level, nxt, lfo, r;
      mod_result_t res;
      level = 0;
      case (env_stage)
         STAGE_DELAY: begin
            nxt         = frames_done + 1;
            frames_done = nxt & FRAME_MASK;
            if (nxt > stage_len) begin
               enter_next_stage();
            end
         end
         STAGE_ATTACK: begin
            level = frames_done * longint'(cfg_gain);
            if (level > UNITY) begin
               level = UNITY;
            end
            nxt         = frames_done + 1;
            frames_done = nxt & FRAME_MASK;
            if (nxt >= stage_len) begin
               enter_next_stage();
            end
         end
         STAGE_SUSTAIN: level = UNITY;
         default: ;
      endcase
      lfo       = (level * wave_sample() * longint'(cfg_depth) + LFO_ROUND) >>> 40;
      phase_acc = (phase_acc + longint'(cfg_step)) & PHASE_MASK;
      if (cfg_mult) begin
         r = (longint'(s) * (16384 + lfo) + 16384) >>> 15;
      end else begin
         r = longint'(s) + lfo;
      end
      r          = clamp_q15(r);
      res.sample = r[15:0];
      res.active = (env_stage != STAGE_OFF);
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      mod_result_t want;
      if (reset) begin
         cfg_delay   = '0;
         cfg_attack  = '0;
         cfg_gain    = '0;
         cfg_step    = '0;
         cfg_wave    = WAVE_SINE;
         cfg_depth   = '0;
         cfg_mult    = 1'b0;
         env_stage   = STAGE_OFF;
         frames_done = 0;
         stage_len   = 0;
         phase_acc   = 0;
         expected_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_DELAY_FRAMES:    cfg_delay  = csr_wdata[23:0];
               REG_ATTACK_FRAMES:   cfg_attack = csr_wdata[23:0];
               REG_ATTACK_GAIN:     cfg_gain   = csr_wdata[23:0];
               REG_PHASE_INCREMENT: cfg_step   = csr_wdata[23:0];
               REG_WAVE_SHAPE:      cfg_wave   = wave_shape_type'(csr_wdata[1:0]);
               REG_MOD_AMOUNT:      cfg_depth  = csr_wdata[15:0];
               REG_MULTIPLY_MODE:   cfg_mult   = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result: sample_out %0d envelope_active %0b",
                           $time, rsp_sample_out, rsp_envelope_active);
               end
            end else begin
               want = expected_q.pop_front();
               if (rsp_sample_out !== want.sample || rsp_envelope_active !== want.active) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: mismatch: sample_out exp %0d got %0d, envelope_active exp %0b got %0b",
                              $time, want.sample, rsp_sample_out, want.active,
                              rsp_envelope_active);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            // mode high restarts the envelope and gives no result
            if (req_mode) begin
               env_stage = STAGE_OFF;
               phase_acc = 0;
               enter_next_stage();
            end else begin
               expected_q.push_back(modulate_sample(req_sample_in));
            end
         end
      end
      fail_count <= mismatches;
      pending    <= expected_q.size();
   end

endmodule

// ----- dv/lfo_envelope_modulator_tb.sv -----
`timescale 1ns / 100ps

module lfo_envelope_modulator_tb;
   import lfoem_pkg::*;

   localparam logic MODE_SAMPLE    = 1'b0;
   localparam logic MODE_TRIGGER   = 1'b1;
   localparam int   MAX_IDLE       = 14;
   // a sample works through the sequencer states inside the block; a trigger is taken in idle
   localparam int   SETTLE_CYCLES  = 12;
   localparam int   HOLD_CYCLES    = 400;
   // several times the slowest legal gap: hold-off, sender idle and block latency
   localparam int   WATCHDOG_LIMIT = 2000;
   localparam int   RANDOM_PHASES  = 8;
   localparam int   PHASE_ITEMS    = 125;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_mode      = MODE_SAMPLE;
   logic signed [15:0]     req_sample_in = '0;
   logic                   rsp_ready     = 1'b0;
   logic                   csr_write_en  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index     = REG_DELAY_FRAMES;
   logic [CFG_W-1:0]       csr_wdata     = '0;

   wire                    req_ready;
   wire                    rsp_valid;
   wire signed [15:0]      rsp_sample_out;
   wire                    rsp_envelope_active;

   int fail_count;
   int pending;
   int stall_cycles = 0;
   // calm stretches: no idling on that side
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;

   always #2 clock = ~clock;

   lfo_envelope_modulator uut (.*);

   lfo_envelope_modulator_checker lfo_check (.*);

   function automatic int idle_draw(input bit calm);
      return calm ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   // one register write per clock; caller drops the enable afterwards
   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
   endtask

   // Called in the time step of the last accepted transaction. It first waits on a clock
   // edge, so that the checker's count already holds that transaction.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [23:0] delay_len, input logic [23:0] attack_len,
                                 input logic [23:0] gain, input logic [23:0] step,
                                 input wave_shape_type shape, input logic signed [15:0] depth,
                                 input logic mult);
      wait_for_drain();
      csr_put(REG_DELAY_FRAMES, delay_len);
      csr_put(REG_ATTACK_FRAMES, attack_len);
      csr_put(REG_ATTACK_GAIN, gain);
      csr_put(REG_PHASE_INCREMENT, step);
      csr_put(REG_WAVE_SHAPE, {22'b0, shape});
      csr_put(REG_MOD_AMOUNT, {8'b0, depth});
      csr_put(REG_MULTIPLY_MODE, {23'b0, mult});
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Returns in the time step of acceptance. Valid is only lowered when a gap follows,
   // so back-to-back transactions keep it high.
   task automatic send_item(input logic m, input logic signed [15:0] s);
      int gap;
      gap = idle_draw(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_sample_in <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   // stimulus
   initial begin
      logic [23:0]        delay_len, attack_len, gain, step;
      wave_shape_type     shape;
      logic signed [15:0] depth;
      logic               mult;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // no trigger yet, envelope off: add mode passes the sample through
      send_item(MODE_SAMPLE, 16'sh7FFF);
      send_item(MODE_SAMPLE, -16'sh8000);

      // envelope still off, multiply mode halves the sample
      apply_settings(24'd0, 24'd0, 24'd0, 24'd0, WAVE_SINE, 16'sd0, 1'b1);
      send_item(MODE_SAMPLE, -16'sh8000);
      send_item(MODE_SAMPLE, 16'sh7FFF);
      send_item(MODE_SAMPLE, -16'sd1);

      // two delay samples, three attack samples with the ramp capped at unity, then
      // sustain; square wave at full negative depth drives the sum into both rails
      apply_settings(24'd1, 24'd3, 24'hFFFFFF, 24'h400000, WAVE_SQUARE, -16'sh8000, 1'b0);
      send_item(MODE_TRIGGER, 16'sh7FFF);
      send_item(MODE_SAMPLE, 16'sh7FFF);
      send_item(MODE_SAMPLE, -16'sh8000);
      send_item(MODE_SAMPLE, 16'sh7FFF);
      send_item(MODE_SAMPLE, 16'sh7FFF);
      send_item(MODE_SAMPLE, 16'sh7FFF);
      send_item(MODE_SAMPLE, -16'sh8000);

      // zero-length delay and attack: straight to sustain; triangle hits its
      // negative extreme at three quarters of a turn
      apply_settings(24'd0, 24'd0, 24'h7FFFFF, 24'h400000, WAVE_TRIANGLE, 16'sh7FFF, 1'b1);
      send_item(MODE_TRIGGER, -16'sh8000);
      send_item(MODE_SAMPLE, 16'sh7FFF);
      send_item(MODE_SAMPLE, -16'sh8000);
      send_item(MODE_SAMPLE, 16'sh4000);
      send_item(MODE_SAMPLE, -16'sh8000);

      // saw with the largest step, so the phase wraps on each step after the first
      apply_settings(24'd0, 24'd2, 24'h800000, 24'hFFFFFF, WAVE_SAW, 16'sh7FFF, 1'b0);
      send_item(MODE_TRIGGER, 16'sd0);
      send_item(MODE_SAMPLE, 16'sh1234);
      send_item(MODE_SAMPLE, -16'sh8000);
      send_item(MODE_SAMPLE, 16'sh7FFF);

      apply_settings(24'd0, 24'd0, 24'd0, 24'h0C0000, WAVE_SINE, -16'sh8000, 1'b1);
      send_item(MODE_TRIGGER, 16'sh5A5A);
      send_item(MODE_SAMPLE, 16'sh7FFF);
      send_item(MODE_SAMPLE, -16'sh8000);
      send_item(MODE_SAMPLE, 16'sh7FFF);

      // random phases: each starts from a trigger with fresh settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            // every register at its top value; the delay stage never ends here
            delay_len  = 24'hFFFFFF;
            attack_len = 24'hFFFFFF;
            gain       = 24'hFFFFFF;
            step       = 24'hFFFFFF;
            shape      = WAVE_SQUARE;
            depth      = 16'sh7FFF;
            mult       = 1'b1;
         end else if (p == 1) begin
            delay_len  = '0;
            attack_len = '0;
            gain       = '0;
            step       = '0;
            shape      = WAVE_SINE;
            depth      = -16'sh8000;
            mult       = 1'b0;
         end else begin
            // short stages so the envelope gets through to sustain between triggers
            delay_len  = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(1, 12));
            attack_len = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(1, 16));
            case ($urandom_range(0, 3))
               0:       gain = 24'hFFFFFF;
               1:       gain = 24'($urandom);
               default: gain = (attack_len == 0) ? 24'd0 : 24'(32'h100_0000 / attack_len);
            endcase
            step  = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(1, 16'hFFFF));
            shape = wave_shape_type'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
               0:       depth = 16'sh7FFF;
               1:       depth = -16'sh8000;
               default: depth = 16'($urandom);
            endcase
            mult = 1'($urandom_range(0, 1));
         end
         tx_calm = ($urandom_range(0, 3) == 0);
         apply_settings(delay_len, attack_len, gain, step, shape, depth, mult);
         send_item(MODE_TRIGGER, 16'($urandom));
         for (int n = 1; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) begin
               send_item(MODE_TRIGGER, 16'($urandom));
            end else begin
               case ($urandom_range(0, 7))
                  0:       send_item(MODE_SAMPLE, 16'sh7FFF);
                  1:       send_item(MODE_SAMPLE, -16'sh8000);
                  2:       send_item(MODE_SAMPLE, 16'sd0);
                  default: send_item(MODE_SAMPLE, 16'($urandom));
               endcase
            end
         end
      end

      wait_for_drain();
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // result side: random stalls per transaction, two long hold-offs so the block
   // fills and back-pressures the sender
   initial begin
      int taken;
      int gap;
      taken = 0;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (taken == 150 || taken == 600) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (taken % 64 == 0) begin
            rx_calm = ($urandom_range(0, 3) == 0);
         end
         gap = idle_draw(rx_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // watchdog: any transaction or register write counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule

// ----- sim.f -----
rtl/core/lfoem_pkg.sv
rtl/core/lfoem_env.sv
rtl/core/lfoem_wave.sv
rtl/core/lfoem_mul.sv
rtl/core/lfo_envelope_modulator.sv
rtl/core/lfoem_checker.sv
dv/lfo_envelope_modulator_checker.sv
dv/lfo_envelope_modulator_tb.sv
